// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define SHA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// Checked at every clock edge, reset included.
`define SHA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("%m: assertion failed");

`endif

// ----- sv/sha256_pkg.sv -----
package sha256_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_ADD,
    ST_PAD80,
    ST_ZERO,
    ST_LEN,
    ST_OUT
  } state_e;

  // Source of the byte shifted into the block register.
  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      shift_en;
    byte_sel_e sel;
    logic      cnt_inc;
    logic      comp_start;
    logic      round_en;
    logic      chain_add;
    logic      out_adv;
    logic      msg_clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_last;
    logic fill_at_len;
    logic round_last;
    logic word_last;
  } sts_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] FILL_LEN = 6'd56;

  // Round constants.
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Initial hash value.
  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage

// ----- sv/sha256_if.sv -----
// Input channel: one message byte a beat.
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_byte;

  modport source (output valid, data_byte, byte_valid, last_byte, input ready);
  modport sink (input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

// Output channel: one digest word a beat.
interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_pos;
  logic        last_word;

  modport source (output valid, digest_word, word_pos, last_word, input ready);
  modport sink (input valid, digest_word, word_pos, last_word, output ready);
endinterface

// ----- sv/sha256_ctrl.sv -----
module sha256_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               byte_valid_i,
  input  logic               last_byte_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  sha256_pkg::sts_t   sts_i,
  output sha256_pkg::cmd_t   cmd_o
);

  sha256_pkg::state_e state_q, state_d;
  sha256_pkg::state_e ret_q, ret_d;

  // State and return-state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256_pkg::ST_IDLE;
      ret_q   <= sha256_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // Next state. A full block sends the machine to the compression and
  // remembers where to carry on afterwards.
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      sha256_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (byte_valid_i && sts_i.fill_last) begin
            state_d = sha256_pkg::ST_COMP;
            ret_d   = last_byte_i ? sha256_pkg::ST_PAD80 : sha256_pkg::ST_IDLE;
          end else if (last_byte_i) begin
            state_d = sha256_pkg::ST_PAD80;
          end
        end
      end
      sha256_pkg::ST_COMP: begin
        if (sts_i.round_last) begin
          state_d = sha256_pkg::ST_ADD;
        end
      end
      sha256_pkg::ST_ADD: begin
        state_d = ret_q;
      end
      sha256_pkg::ST_PAD80: begin
        if (sts_i.fill_last) begin
          state_d = sha256_pkg::ST_COMP;
          ret_d   = sha256_pkg::ST_ZERO;
        end else begin
          state_d = sha256_pkg::ST_ZERO;
        end
      end
      sha256_pkg::ST_ZERO: begin
        if (sts_i.fill_at_len) begin
          state_d = sha256_pkg::ST_LEN;
        end else if (sts_i.fill_last) begin
          state_d = sha256_pkg::ST_COMP;
          ret_d   = sha256_pkg::ST_ZERO;
        end
      end
      sha256_pkg::ST_LEN: begin
        if (sts_i.fill_last) begin
          state_d = sha256_pkg::ST_COMP;
          ret_d   = sha256_pkg::ST_OUT;
        end
      end
      sha256_pkg::ST_OUT: begin
        if (out_ready_i && sts_i.word_last) begin
          state_d = sha256_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sha256_pkg::ST_IDLE;
      end
    endcase
  end

  // Handshake and datapath commands.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.sel   = sha256_pkg::SEL_DATA;
    case (state_q)
      sha256_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && byte_valid_i) begin
          cmd_o.shift_en   = 1'b1;
          cmd_o.cnt_inc    = 1'b1;
          cmd_o.comp_start = sts_i.fill_last;
        end
      end
      sha256_pkg::ST_COMP: begin
        cmd_o.round_en = 1'b1;
      end
      sha256_pkg::ST_ADD: begin
        cmd_o.chain_add = 1'b1;
      end
      sha256_pkg::ST_PAD80: begin
        cmd_o.shift_en   = 1'b1;
        cmd_o.sel        = sha256_pkg::SEL_PAD;
        cmd_o.comp_start = sts_i.fill_last;
      end
      sha256_pkg::ST_ZERO: begin
        if (!sts_i.fill_at_len) begin
          cmd_o.shift_en   = 1'b1;
          cmd_o.sel        = sha256_pkg::SEL_ZERO;
          cmd_o.comp_start = sts_i.fill_last;
        end
      end
      sha256_pkg::ST_LEN: begin
        cmd_o.shift_en   = 1'b1;
        cmd_o.sel        = sha256_pkg::SEL_LEN;
        cmd_o.comp_start = sts_i.fill_last;
      end
      sha256_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_adv   = 1'b1;
          cmd_o.msg_clear = sts_i.word_last;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- sv/sha256_dp.sv -----
module sha256_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sha256_pkg::cmd_t cmd_i,
  output sha256_pkg::sts_t sts_o,
  input  logic [7:0]       data_byte_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_pos_o,
  output logic             last_word_o
);

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  // Block register: 64 bytes while loading, 16 schedule words while
  // compressing. The oldest word sits at the top.
  logic [511:0] win_q, win_d;
  logic [5:0]   fill_q;
  logic [60:0]  cnt_q;
  logic [5:0]   rnd_q;
  logic [2:0]   idx_q;
  logic [31:0]  wk_q [8];
  logic [31:0]  wk_d [8];
  logic [31:0]  hv_q [8];

  logic [63:0]  len_bits;
  logic [2:0]   len_sel;
  logic [7:0]   len_byte;
  logic [7:0]   shift_byte;
  logic [31:0]  w_top, w_1, w_9, w_14, w_new;
  logic [31:0]  t1, t2, ch, mj;

  // Length bytes go out most significant first as the fill runs 56 to 63.
  assign len_bits = {cnt_q, 3'b000};
  assign len_sel  = ~fill_q[2:0];
  assign len_byte = len_bits[{len_sel, 3'b000} +: 8];

  always_comb begin
    case (cmd_i.sel)
      sha256_pkg::SEL_DATA: shift_byte = data_byte_i;
      sha256_pkg::SEL_PAD:  shift_byte = sha256_pkg::PAD_BYTE;
      sha256_pkg::SEL_ZERO: shift_byte = 8'h00;
      sha256_pkg::SEL_LEN:  shift_byte = len_byte;
      default:              shift_byte = 8'h00;
    endcase
  end

  // Message schedule: the word sixteen rounds ahead enters at the bottom.
  assign w_top = win_q[511:480];
  assign w_1   = win_q[479:448];
  assign w_9   = win_q[223:192];
  assign w_14  = win_q[63:32];
  assign w_new = ssig1(w_14) + w_9 + ssig0(w_1) + w_top;

  // One compression round.
  assign ch = (wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6]);
  assign mj = (wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]);
  assign t1 = wk_q[7] + bsig1(wk_q[4]) + ch + sha256_pkg::ROUND_K[rnd_q] + w_top;
  assign t2 = bsig0(wk_q[0]) + mj;

  always_comb begin
    win_d = win_q;
    for (int i = 0; i < 8; i++) begin
      wk_d[i] = wk_q[i];
    end
    if (cmd_i.shift_en) begin
      win_d = {win_q[503:0], shift_byte};
    end else if (cmd_i.round_en) begin
      win_d = {win_q[479:0], w_new};
    end
    if (cmd_i.comp_start) begin
      for (int i = 0; i < 8; i++) begin
        wk_d[i] = hv_q[i];
      end
    end else if (cmd_i.round_en) begin
      wk_d[0] = t1 + t2;
      wk_d[1] = wk_q[0];
      wk_d[2] = wk_q[1];
      wk_d[3] = wk_q[2];
      wk_d[4] = wk_q[3] + t1;
      wk_d[5] = wk_q[4];
      wk_d[6] = wk_q[5];
      wk_d[7] = wk_q[6];
    end
  end

  // Block and working registers carry no reset.
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    for (int i = 0; i < 8; i++) begin
      wk_q[i] <= wk_d[i];
    end
  end

  // Counters and chaining value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cnt_q  <= '0;
      rnd_q  <= '0;
      idx_q  <= '0;
      for (int i = 0; i < 8; i++) begin
        hv_q[i] <= sha256_pkg::H_INIT[i];
      end
    end else begin
      if (cmd_i.shift_en) begin
        fill_q <= fill_q + 6'd1;
      end
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 61'd1;
      end
      if (cmd_i.comp_start) begin
        rnd_q <= '0;
      end else if (cmd_i.round_en) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (cmd_i.out_adv) begin
        idx_q <= idx_q + 3'd1;
      end
      if (cmd_i.msg_clear) begin
        cnt_q <= '0;
        for (int i = 0; i < 8; i++) begin
          hv_q[i] <= sha256_pkg::H_INIT[i];
        end
      end else if (cmd_i.chain_add) begin
        for (int i = 0; i < 8; i++) begin
          hv_q[i] <= hv_q[i] + wk_q[i];
        end
      end
    end
  end

  assign sts_o.fill_last   = (fill_q == 6'd63);
  assign sts_o.fill_at_len = (fill_q == sha256_pkg::FILL_LEN);
  assign sts_o.round_last  = (rnd_q == 6'd63);
  assign sts_o.word_last   = (idx_q == 3'd7);

  assign digest_word_o = hv_q[idx_q];
  assign word_pos_o    = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

endmodule

// ----- sv/sha256_byte_stream_hasher.sv -----
// Channel  Dir  Payload                                   Beat
// in_i     in   data_byte[7:0] byte_valid last_byte       one message byte
// out_o    out  digest_word[31:0] word_pos[2:0] last_word one digest word
//
// Data bytes are taken one per cycle while in_i.ready is high; the byte that
// fills a block starts the compression (64 rounds in the single round unit,
// then the chaining add). A last item then shifts in one padding byte per
// cycle up to the end of the block, pauses where the zero fill meets the
// length field, hashes each block it closes, then gives eight output beats.
// Reset is asynchronous and loads the initial hash value and clears counts.
// in_i.ready is low from a full block or a last item until the compression
// ends, or until the eighth digest word is taken.
module sha256_byte_stream_hasher (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sha256_in_if.sink            in_i,
  sha256_out_if.source         out_o
);

  sha256_pkg::cmd_t cmd;
  sha256_pkg::sts_t sts;

  sha256_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .byte_valid_i (in_i.byte_valid),
    .last_byte_i  (in_i.last_byte),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  sha256_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .data_byte_i   (in_i.data_byte),
    .digest_word_o (out_o.digest_word),
    .word_pos_o    (out_o.word_pos),
    .last_word_o   (out_o.last_word)
  );

endmodule

// ----- sv/sha256_chk.sv -----
`include "assert_macros.svh"

module sha256_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] digest_word_i,
  input logic [2:0]  word_pos_i,
  input logic        last_word_i
);

  logic       out_beat;
  logic [2:0] next_pos;

  // An output beat and the position that should follow it.
  assign out_beat = out_valid_i && out_ready_i;
  assign next_pos = word_pos_i + 3'd1;

  // No byte is taken while a digest is being delivered.
  `SHA_ASSERT_ALWAYS(a_no_overlap, !(in_ready_i && out_valid_i))

  // The flag for the final word matches its position.
  `SHA_ASSERT(a_last_pos, out_valid_i |-> (last_word_i == (word_pos_i == 3'd7)))

  // Words come out in order without a gap.
  `SHA_ASSERT(a_word_seq, (out_beat && !last_word_i) |=> (out_valid_i && word_pos_i == $past(next_pos)))

  // The digest ends after its final beat.
  `SHA_ASSERT(a_end_digest, (out_beat && last_word_i) |=> !out_valid_i)

  // A stalled word holds.
  `SHA_ASSERT(a_out_hold, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(digest_word_i)))

endmodule

bind sha256_byte_stream_hasher sha256_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .digest_word_i (out_o.digest_word),
  .word_pos_i    (out_o.word_pos),
  .last_word_i   (out_o.last_word)
);
